// File: rtl/prrt_pkg.sv
// Types and codes shared by the pin range registry table.
package prrt_pkg;

    localparam int PIN_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int TOTAL_W = 15;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 2;

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_REGISTER   = 2'd1;
    localparam logic [1:0] OP_UNREGISTER = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_OUTSIDE  = 3'd2;
    localparam logic [2:0] ST_OVERLAP  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_NOTBASE  = 3'd6;

    localparam logic [CFG_W-1:0] REG_LAST_PIN    = 2'd0;
    localparam logic [CFG_W-1:0] REG_ONCHIP_LAST = 2'd1;

    localparam logic [PIN_W-1:0] LAST_PIN_RESET    = 10'd1023;
    localparam logic [PIN_W-1:0] ONCHIP_LAST_RESET = 10'd255;

    typedef struct packed {
        logic [1:0]        operation;
        logic [PIN_W-1:0]  pin_index;
        logic [SIZE_W-1:0] range_size;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [PIN_W-1:0]   offset;
        logic [TOTAL_W-1:0] total_pins;
    } rsp_t;

endpackage

// File: rtl/pin_range_registry_table.sv
// Pin range registry table: slot table with a one-slot-per-cycle scan sequencer.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  request   | s_valid / s_ready     | s_data   (operation, pin, size)
//  response  | m_valid / m_ready     | m_data   (status, slot, offset, total)
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request is scanned by one compare unit, one slot per cycle, and
// then the finish step resolves status and updates the table and the running pin total.
// The response sits in an output register; the next request is taken while it waits.
// If a finished response finds the output register still full, the sequencer holds.
// Reset is synchronous: all slots empty, total zero, window registers at defaults.
module pin_range_registry_table
    import prrt_pkg::*;
#(
    parameter int NUM_SLOTS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [PIN_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg;
    req_t               req_reg;
    logic [PIN_W-1:0]   last_pin_reg, onchip_last_reg;

    logic [NUM_SLOTS-1:0] slot_live_reg;
    logic [PIN_W-1:0]     slot_base_reg [NUM_SLOTS];
    logic [SIZE_W-1:0]    slot_size_reg [NUM_SLOTS];
    logic [TOTAL_W-1:0]   total_reg;

    logic               found_reg, free_found_reg, overlap_reg;
    logic [IDX_W-1:0]   cover_idx_reg, free_idx_reg;
    logic [PIN_W-1:0]   cover_base_reg;
    logic [SIZE_W-1:0]  cover_size_reg;

    logic               m_valid_reg;
    rsp_t               m_data_reg;

    // scan compare unit
    logic               cur_live;
    logic [PIN_W-1:0]   cur_base;
    logic [SIZE_W-1:0]  cur_size;
    logic [PIN_W+1:0]   cur_end, req_end;
    logic               cover_hit, overlap_hit;

    // finish stage
    logic               out_free, window_bad;
    rsp_t               rsp_next;
    logic               do_fill, do_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign cur_live    = slot_live_reg[idx_reg];
    assign cur_base    = slot_base_reg[idx_reg];
    assign cur_size    = slot_size_reg[idx_reg];
    assign cur_end     = {2'b00, cur_base} + {1'b0, cur_size};
    assign req_end     = {2'b00, req_reg.pin_index} + {1'b0, req_reg.range_size};
    assign cover_hit   = cur_live && (req_reg.pin_index >= cur_base)
                         && ({2'b00, req_reg.pin_index} < cur_end);
    assign overlap_hit = cur_live && ({2'b00, req_reg.pin_index} < cur_end)
                         && ({2'b00, cur_base} < req_end);
    assign window_bad  = (req_end > ({2'b00, last_pin_reg} + 12'd1))
                         || (req_reg.pin_index <= onchip_last_reg);

    always_comb begin
        rsp_next            = '0;
        rsp_next.status     = ST_NOTFOUND;
        rsp_next.total_pins = total_reg;
        do_fill             = 1'b0;
        do_free             = 1'b0;
        case (req_reg.operation)
            OP_LOOKUP: begin
                if (found_reg) begin
                    rsp_next.status = ST_OK;
                    rsp_next.slot   = SLOT_W'(cover_idx_reg);
                    rsp_next.offset = req_reg.pin_index - cover_base_reg;
                end
            end
            OP_REGISTER: begin
                if (req_reg.range_size == '0) begin
                    rsp_next.status = ST_ZERO;
                end else if (window_bad) begin
                    rsp_next.status = ST_OUTSIDE;
                end else if (overlap_reg) begin
                    rsp_next.status = ST_OVERLAP;
                end else if (!free_found_reg) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    rsp_next.status     = ST_OK;
                    rsp_next.slot       = SLOT_W'(free_idx_reg);
                    rsp_next.total_pins = total_reg + TOTAL_W'(req_reg.range_size);
                    do_fill             = 1'b1;
                end
            end
            OP_UNREGISTER: begin
                if (!found_reg) begin
                    rsp_next.status = ST_NOTFOUND;
                end else if (cover_base_reg != req_reg.pin_index) begin
                    rsp_next.status = ST_NOTBASE;
                end else begin
                    rsp_next.status     = ST_OK;
                    rsp_next.slot       = SLOT_W'(cover_idx_reg);
                    rsp_next.total_pins = total_reg - TOTAL_W'(cover_size_reg);
                    do_free             = 1'b1;
                end
            end
            default: begin
                rsp_next.status = ST_NOTFOUND;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (idx_reg == LAST_IDX) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            last_pin_reg    <= LAST_PIN_RESET;
            onchip_last_reg <= ONCHIP_LAST_RESET;
            slot_live_reg   <= '0;
            total_reg       <= '0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            overlap_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_base_reg[i] <= '0;
                slot_size_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                if (cfg_index == REG_LAST_PIN) last_pin_reg <= cfg_data;
                if (cfg_index == REG_ONCHIP_LAST) onchip_last_reg <= cfg_data;
            end

            if ((state_reg == S_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg        <= s_data;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        overlap_reg    <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (cover_hit && !found_reg) begin
                        found_reg      <= 1'b1;
                        cover_idx_reg  <= idx_reg;
                        cover_base_reg <= cur_base;
                        cover_size_reg <= cur_size;
                    end
                    if (!cur_live && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    if (overlap_hit) overlap_reg <= 1'b1;
                    if (idx_reg != LAST_IDX) idx_reg <= idx_reg + 1'b1;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_data_reg  <= rsp_next;
                        total_reg   <= rsp_next.total_pins;
                        if (do_fill) begin
                            slot_live_reg[free_idx_reg] <= 1'b1;
                            slot_base_reg[free_idx_reg] <= req_reg.pin_index;
                            slot_size_reg[free_idx_reg] <= req_reg.range_size;
                        end
                        if (do_free) begin
                            slot_live_reg[cover_idx_reg] <= 1'b0;
                            slot_base_reg[cover_idx_reg] <= '0;
                            slot_size_reg[cover_idx_reg] <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // empty table carries no pins
    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_live_reg == '0) |-> (total_reg == '0))
        else $error("pin total nonzero with empty table");

    // failed requests report slot and offset zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status != ST_OK))
            |-> (m_data_reg.slot == '0) && (m_data_reg.offset == '0))
        else $error("failed response with nonzero slot or offset");

    // a response is loaded only from the finish step
    a_rsp_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("response raised outside finish step");

    // total never exceeds table capacity
    a_total_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(total_reg) <= 32'(NUM_SLOTS * 1024))
        else $error("pin total beyond table capacity");

endmodule

// File: tb/prrt_tb_pkg.sv
// Response predictor and scoreboard for the pin range registry table testbench.
package prrt_tb_pkg;
    import prrt_pkg::*;

    localparam int TABLE_SLOTS = 4;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class pin_table_checker;
        bit                slot_used  [TABLE_SLOTS];
        logic [PIN_W-1:0]  slot_first [TABLE_SLOTS];
        logic [SIZE_W-1:0] slot_len   [TABLE_SLOTS];
        logic [PIN_W-1:0]  max_pin;
        logic [PIN_W-1:0]  chip_top;
        rsp_t              expected_responses[$];
        int                errors;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_first[i] = '0;
                slot_len[i]   = '0;
            end
            max_pin  = LAST_PIN_RESET;
            chip_top = ONCHIP_LAST_RESET;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_W-1:0] idx, logic [PIN_W-1:0] val);
            if (idx == REG_LAST_PIN) begin
                max_pin = val;
            end else if (idx == REG_ONCHIP_LAST) begin
                chip_top = val;
            end
        endfunction

        function int cover_slot(int unsigned pin);
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i] && pin >= int'(slot_first[i]) &&
                    pin < int'(slot_first[i]) + int'(slot_len[i])) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function logic [TOTAL_W-1:0] live_total();
            int unsigned sum;
            sum = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i]) begin
                    sum += int'(slot_len[i]);
                end
            end
            return TOTAL_W'(sum);
        endfunction

        function rsp_t predict_response(req_t r);
            rsp_t        rsp;
            int          hit;
            int          free_slot;
            bit          overlap;
            int unsigned pin;
            int unsigned len;
            pin = r.pin_index;
            len = r.range_size;
            rsp.status = ST_NOTFOUND;
            rsp.slot   = '0;
            rsp.offset = '0;
            case (r.operation)
                OP_LOOKUP: begin
                    hit = cover_slot(pin);
                    if (hit >= 0) begin
                        rsp.status = ST_OK;
                        rsp.slot   = SLOT_W'(hit);
                        rsp.offset = PIN_W'(pin - int'(slot_first[hit]));
                    end
                end
                OP_REGISTER: begin
                    if (len == 0) begin
                        rsp.status = ST_ZERO;
                    end else if (pin + len - 1 > int'(max_pin) || pin <= int'(chip_top)) begin
                        rsp.status = ST_OUTSIDE;
                    end else begin
                        overlap   = 1'b0;
                        free_slot = -1;
                        for (int i = 0; i < TABLE_SLOTS; i++) begin
                            if (slot_used[i]) begin
                                if (pin < int'(slot_first[i]) + int'(slot_len[i]) &&
                                    int'(slot_first[i]) < pin + len) begin
                                    overlap = 1'b1;
                                end
                            end else if (free_slot < 0) begin
                                free_slot = i;
                            end
                        end
                        if (overlap) begin
                            rsp.status = ST_OVERLAP;
                        end else if (free_slot < 0) begin
                            rsp.status = ST_FULL;
                        end else begin
                            slot_used[free_slot]  = 1'b1;
                            slot_first[free_slot] = r.pin_index;
                            slot_len[free_slot]   = r.range_size;
                            rsp.status = ST_OK;
                            rsp.slot   = SLOT_W'(free_slot);
                        end
                    end
                end
                OP_UNREGISTER: begin
                    hit = cover_slot(pin);
                    if (hit < 0) begin
                        rsp.status = ST_NOTFOUND;
                    end else if (int'(slot_first[hit]) != pin) begin
                        rsp.status = ST_NOTBASE;
                    end else begin
                        slot_used[hit]  = 1'b0;
                        slot_first[hit] = '0;
                        slot_len[hit]   = '0;
                        rsp.status = ST_OK;
                        rsp.slot   = SLOT_W'(hit);
                    end
                end
                default: begin
                end
            endcase
            rsp.total_pins = live_total();
            return rsp;
        endfunction

        function void note_request(req_t r);
            expected_responses.push_back(predict_response(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_responses.size() == 0) begin
                $error("response with no request pending");
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $error("offset: expected %0d, got %0d", want.offset, got.offset);
                errors++;
            end
            if (got.total_pins !== want.total_pins) begin
                $error("total_pins: expected %0d, got %0d", want.total_pins, got.total_pins);
                errors++;
            end
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function bit pick_live(output int unsigned first, output int unsigned len);
            int used_list[$];
            int pick;
            first = 0;
            len   = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i]) begin
                    used_list.push_back(i);
                end
            end
            if (used_list.size() == 0) begin
                return 1'b0;
            end
            pick  = used_list[$urandom_range(0, used_list.size() - 1)];
            first = slot_first[pick];
            len   = slot_len[pick];
            return 1'b1;
        endfunction
    endclass

endpackage

// File: tb/tb.sv
// Top-level testbench for the pin range registry table.
module tb;
    import prrt_pkg::*;
    import prrt_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * (TABLE_SLOTS + 2);
    localparam int HOLD_CYCLES  = 300;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    req_t             s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    rsp_t             m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_index = '0;
    logic [PIN_W-1:0] cfg_data  = '0;

    bit steady      = 1'b0;
    int rsp_hold    = 0;
    int cycle_count = 0;

    pin_table_checker table_chk = new();

    pin_range_registry_table #(
        .NUM_SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_req(input req_t r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        table_chk.note_request(r);
    endtask

    task automatic send_op(input logic [1:0] op, input int unsigned pin, input int unsigned len);
        req_t r;
        r.operation  = op;
        r.pin_index  = PIN_W'(pin);
        r.range_size = SIZE_W'(len);
        send_req(r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (table_chk.pending() > 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [PIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        table_chk.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_window(input int unsigned last, input int unsigned onchip);
        write_reg(REG_LAST_PIN, PIN_W'(last));
        write_reg(REG_ONCHIP_LAST, PIN_W'(onchip));
    endtask

    // mostly in-window registers and live-range lookups/removals, some noise
    function automatic req_t random_request();
        req_t        r;
        int unsigned lo;
        int unsigned hi;
        int unsigned roll;
        int unsigned b;
        int unsigned len;
        int unsigned lb;
        int unsigned ll;
        bit          have;
        lo   = int'(table_chk.chip_top) + 1;
        hi   = table_chk.max_pin;
        have = table_chk.pick_live(lb, ll);
        roll = $urandom_range(0, 99);
        r.operation  = OP_LOOKUP;
        r.pin_index  = PIN_W'($urandom());
        r.range_size = SIZE_W'($urandom_range(0, 1024));
        if (roll < 35) begin
            r.operation = OP_REGISTER;
            if (lo <= hi && $urandom_range(0, 9) < 8) begin
                if (have && $urandom_range(0, 3) == 0) begin
                    b = lb + $urandom_range(0, 2);
                end else begin
                    b = $urandom_range(lo, hi);
                end
                if (b > hi) b = hi;
                if (b < lo) b = lo;
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(1, hi - b + 2);
                end else begin
                    len = $urandom_range(1, (hi - b + 1 < 32) ? hi - b + 1 : 32);
                end
                r.pin_index  = PIN_W'(b);
                r.range_size = SIZE_W'(len);
            end
        end else if (roll < 65) begin
            r.operation = OP_LOOKUP;
            if (have && $urandom_range(0, 3) != 0) begin
                b = lb + $urandom_range(0, ll);
                if (b > 1023) b = 1023;
                r.pin_index = PIN_W'(b);
            end
        end else if (roll < 90) begin
            r.operation = OP_UNREGISTER;
            if (have && $urandom_range(0, 3) != 0) begin
                b = ($urandom_range(0, 3) == 0) ? lb + $urandom_range(0, ll - 1) : lb;
                r.pin_index = PIN_W'(b);
            end
        end else begin
            r.operation  = 2'($urandom_range(0, 3));
            r.pin_index  = PIN_W'($urandom());
            r.range_size = SIZE_W'($urandom());
        end
        return r;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_req(random_request());
    endtask

    // response side
    initial begin
        int stall;
        int hold_count;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rsp_hold > 0) begin
                m_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < rsp_hold) begin
                    @(posedge aclk);
                    hold_count++;
                end
                rsp_hold = 0;
            end
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            table_chk.check_response(m_data);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window: bases 256..1023
        send_op(OP_LOOKUP, 0, 0);
        send_op(OP_REGISTER, 300, 0);
        send_op(OP_REGISTER, 255, 1);
        send_op(OP_REGISTER, 1023, 2);
        send_op(OP_REGISTER, 256, 1024);
        send_op(OP_REGISTER, 256, 16);
        send_op(OP_REGISTER, 1023, 1);
        send_op(OP_REGISTER, 256, 4);
        send_op(OP_REGISTER, 260, 2);
        send_op(OP_REGISTER, 1000, 24);
        send_op(OP_REGISTER, 272, 8);
        send_op(OP_REGISTER, 500, 100);
        send_op(OP_REGISTER, 700, 1);
        send_op(OP_LOOKUP, 256, 0);
        send_op(OP_LOOKUP, 271, 0);
        send_op(OP_LOOKUP, 1023, 0);
        send_op(OP_LOOKUP, 599, 0);
        send_op(OP_LOOKUP, 600, 0);
        send_op(OP_UNREGISTER, 260, 0);
        send_op(OP_UNREGISTER, 800, 0);
        send_op(OP_UNREGISTER, 256, 0);
        send_op(OP_LOOKUP, 256, 0);
        send_op(OP_REGISTER, 256, 8);
        send_op(OP_UNUSED, 1023, 2047);
        send_op(OP_UNREGISTER, 1023, 0);
        send_op(OP_REGISTER, 300, 2047);
        drain();

        run_random(150);
        drain();

        set_window(1023, 0);
        run_random(120);
        drain();

        set_window(400, 300);
        rsp_hold = HOLD_CYCLES;
        run_random(120);
        drain();

        set_window(0, 0);
        run_random(40);
        drain();

        set_window(1023, 1023);
        run_random(40);
        drain();

        set_window(700, 100);
        steady = 1'b1;
        run_random(150);
        drain();
        steady = 1'b0;

        set_window(1023, 255);
        run_random(130);
        drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (table_chk.errors == 0 && table_chk.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
